@@ rtl/skad_pkg.sv @@
// ----------------------------------------------------------------------------
// skad_pkg: shared types and constants for the SimCC keypoint argmax decoder
// Record format between front and back, register codes, reset values and
// the bin/keypoint count clamp.
// ----------------------------------------------------------------------------
package skad_pkg;

  // Default sizing of the block
  localparam int unsigned MAX_BINS_DEF    = 1024;
  localparam int unsigned MAX_KP_DEF      = 256;
  localparam int unsigned SCORE_W_DEF     = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Widest bin index the record carries (MAX_BINS up to 4096)
  localparam int unsigned IDX_MAX_W = 12;
  // Product of a bin index and a Q8.8 scale
  localparam int unsigned PROD_W    = IDX_MAX_W + 16;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_X_BIN_COUNT    = 3'd0,
    REG_Y_BIN_COUNT    = 3'd1,
    REG_KEYPOINT_COUNT = 3'd2,
    REG_SCALE_X        = 3'd3,
    REG_SCALE_Y        = 3'd4
  } cfg_reg_e;

  // Register reset values
  localparam logic [10:0] X_BIN_COUNT_RST    = 11'd576;
  localparam logic [10:0] Y_BIN_COUNT_RST    = 11'd786;
  localparam logic [8:0]  KEYPOINT_COUNT_RST = 9'd133;
  localparam logic [15:0] SCALE_X_RST        = 16'd128;
  localparam logic [15:0] SCALE_Y_RST        = 16'd128;

  // One decoded keypoint, handed from front to back
  typedef struct packed {
    logic [7:0]           kp_id;
    logic [IDX_MAX_W-1:0] x_idx;
    logic [IDX_MAX_W-1:0] y_idx;
    logic [15:0]          score;
    logic                 found;
  } kp_rec_t;

  // Zero counts as one, anything above the limit as the limit
  function automatic int unsigned clamp_count(int unsigned c, int unsigned hi);
    int unsigned r;
    if (c == 0) begin
      r = 1;
    end else if (c > hi) begin
      r = hi;
    end else begin
      r = c;
    end
    return r;
  endfunction

endpackage

@@ rtl/skad_front.sv @@
// ----------------------------------------------------------------------------
// skad_front: bin intake and running argmax
// Takes one bin score per transfer, tracks the per-axis maximum and its first
// index, and pushes one record into the queue after the last y bin.
// ----------------------------------------------------------------------------
module skad_front #(
  parameter int unsigned MAX_BINS      = skad_pkg::MAX_BINS_DEF,
  parameter int unsigned MAX_KEYPOINTS = skad_pkg::MAX_KP_DEF,
  parameter int unsigned SCORE_WIDTH   = skad_pkg::SCORE_W_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [10:0]             x_bin_count_i,
  input  logic [10:0]             y_bin_count_i,
  input  logic [8:0]              keypoint_count_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [SCORE_WIDTH-1:0]  bin_score_i,
  input  logic                    crop_start_i,
  input  logic                    queue_full_i,
  output logic                    push_o,
  output skad_pkg::kp_rec_t       rec_o
);

  localparam int unsigned IDX_W = $clog2(MAX_BINS);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned KP_W  = (MAX_KEYPOINTS > 1) ? $clog2(MAX_KEYPOINTS) : 1;

  logic signed [SCORE_WIDTH-1:0] best_x_q, best_y_q;
  logic [IDX_W-1:0]              best_x_idx_q, best_y_idx_q;
  logic [IDX_W-1:0]              bin_cnt_q, bin_cnt_d;
  logic                          on_y_q, on_y_d;
  logic [KP_W-1:0]               kp_q, kp_d;

  logic                          accept;
  logic signed [SCORE_WIDTH-1:0] score_in;
  logic [IDX_W-1:0]              cnt_eff;
  logic                          axis_eff;
  logic [KP_W-1:0]               kp_eff;
  logic                          take_x, take_y;
  logic [CNT_W-1:0]              count_x, count_y, count_cur, cnt_inc;
  logic                          last_bin;
  logic [KP_W:0]                 kp_inc, kp_lim;
  logic signed [SCORE_WIDTH-1:0] best_y_nxt, sc_min;
  logic [IDX_W-1:0]              best_y_idx_nxt;
  logic signed [31:0]            sc_ext;

  assign in_ready_o = ~queue_full_i;
  assign accept     = in_valid_i & in_ready_o;
  assign score_in   = $signed(bin_score_i);

  // Crop start restarts counters ahead of this bin
  assign cnt_eff  = crop_start_i ? '0 : bin_cnt_q;
  assign axis_eff = crop_start_i ? 1'b0 : on_y_q;
  assign kp_eff   = crop_start_i ? '0 : kp_q;

  // First bin of an axis loads unconditionally; ties keep the earlier bin
  assign take_x = ~axis_eff & ((cnt_eff == '0) | (score_in > best_x_q));
  assign take_y =  axis_eff & ((cnt_eff == '0) | (score_in > best_y_q));

  // Axis end: counter reaches or passes the clamped count
  assign count_x   = CNT_W'(skad_pkg::clamp_count(32'(x_bin_count_i), MAX_BINS));
  assign count_y   = CNT_W'(skad_pkg::clamp_count(32'(y_bin_count_i), MAX_BINS));
  assign count_cur = axis_eff ? count_y : count_x;
  assign cnt_inc   = {1'b0, cnt_eff} + CNT_W'(1);
  assign last_bin  = (cnt_inc >= count_cur);

  // Keypoint id wraps at the clamped keypoint count
  assign kp_inc = {1'b0, kp_eff} + (KP_W + 1)'(1);
  assign kp_lim = (KP_W + 1)'(skad_pkg::clamp_count(32'(keypoint_count_i), MAX_KEYPOINTS));

  assign push_o = accept & last_bin & axis_eff;

  // Next counter state
  always_comb begin
    bin_cnt_d = bin_cnt_q;
    on_y_d    = on_y_q;
    kp_d      = kp_q;
    if (accept) begin
      bin_cnt_d = last_bin ? '0 : cnt_inc[IDX_W-1:0];
      on_y_d    = last_bin ? ~axis_eff : axis_eff;
      kp_d      = kp_eff;
      if (push_o) begin
        kp_d = (kp_inc >= kp_lim) ? '0 : kp_inc[KP_W-1:0];
      end
    end
  end

  // Build the record from the maxima including this bin
  assign best_y_nxt     = take_y ? score_in : best_y_q;
  assign best_y_idx_nxt = take_y ? cnt_eff : best_y_idx_q;
  assign sc_min         = (best_x_q > best_y_nxt) ? best_y_nxt : best_x_q;
  assign sc_ext         = 32'(sc_min);

  always_comb begin
    rec_o.kp_id = 8'(kp_eff);
    rec_o.x_idx = skad_pkg::IDX_MAX_W'(best_x_idx_q);
    rec_o.y_idx = skad_pkg::IDX_MAX_W'(best_y_idx_nxt);
    rec_o.score = sc_ext[15:0];
    rec_o.found = (sc_min > 0);
  end

  // Hold state between transfers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_x_q     <= '0;
      best_y_q     <= '0;
      best_x_idx_q <= '0;
      best_y_idx_q <= '0;
      bin_cnt_q    <= '0;
      on_y_q       <= 1'b0;
      kp_q         <= '0;
    end else begin
      bin_cnt_q <= bin_cnt_d;
      on_y_q    <= on_y_d;
      kp_q      <= kp_d;
      if (accept && take_x) begin
        best_x_q     <= score_in;
        best_x_idx_q <= cnt_eff;
      end
      if (accept && take_y) begin
        best_y_q     <= score_in;
        best_y_idx_q <= cnt_eff;
      end
    end
  end

  // Bin counter stays inside the bin range
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(bin_cnt_q) < MAX_BINS)
    else $error("bin counter out of range");

endmodule

@@ rtl/skad_queue.sv @@
// ----------------------------------------------------------------------------
// skad_queue: small record queue between front and back
// Lets the bin intake run on while results wait on the output side.
// ----------------------------------------------------------------------------
module skad_queue #(
  parameter int unsigned DEPTH = skad_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  skad_pkg::kp_rec_t wr_rec_i,
  output logic              full_o,
  input  logic              pop_i,
  output skad_pkg::kp_rec_t rd_rec_o,
  output logic              empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  skad_pkg::kp_rec_t mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;

  assign full_o   = (count_q == CNT_W'(DEPTH));
  assign empty_o  = (count_q == '0);
  assign rd_rec_o = mem_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_rec_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= DEPTH)
    else $error("queue count above depth");

endmodule

@@ rtl/skad_back.sv @@
// ----------------------------------------------------------------------------
// skad_back: position scaling and result output
// Multiplies the winning bin indices by the per-axis Q8.8 scales, rounds to
// Q12.4 with saturation and drives the result stream from a register.
// ----------------------------------------------------------------------------
module skad_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [15:0]       scale_x_i,
  input  logic [15:0]       scale_y_i,
  input  logic              empty_i,
  input  skad_pkg::kp_rec_t rec_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        keypoint_id_o,
  output logic [15:0]       pos_x_o,
  output logic [15:0]       pos_y_o,
  output logic [15:0]       score_o,
  output logic              found_o
);

  localparam int unsigned PW = skad_pkg::PROD_W;

  // Product stage
  logic              s1_valid_q;
  logic [PW-1:0]     prod_x_q, prod_y_q;
  logic [7:0]        s1_id_q;
  logic [15:0]       s1_score_q;
  logic              s1_found_q;

  // Output stage
  logic              out_valid_q;
  logic [7:0]        out_id_q;
  logic [15:0]       out_pos_x_q, out_pos_y_q, out_score_q;
  logic              out_found_q;

  logic              out_adv;
  logic [15:0]       pos_x_d, pos_y_d;

  // Round half up to Q12.4 and saturate
  function automatic logic [15:0] to_pos(logic [PW-1:0] p);
    logic [PW:0]   sum;
    logic [PW-4:0] sh;
    sum = {1'b0, p} + (PW + 1)'(8);
    sh  = sum[PW:4];
    return (sh > (PW - 3)'(16'hFFFF)) ? 16'hFFFF : sh[15:0];
  endfunction

  assign out_adv = ~out_valid_q | out_ready_i;
  assign pop_o   = ~empty_i & (~s1_valid_q | out_adv);

  assign pos_x_d = s1_found_q ? to_pos(prod_x_q) : 16'd0;
  assign pos_y_d = s1_found_q ? to_pos(prod_y_q) : 16'd0;

  // Multiply the popped record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pop_o) begin
      s1_valid_q <= 1'b1;
    end else if (out_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      prod_x_q   <= PW'(rec_i.x_idx) * PW'(scale_x_i);
      prod_y_q   <= PW'(rec_i.y_idx) * PW'(scale_y_i);
      s1_id_q    <= rec_i.kp_id;
      s1_score_q <= rec_i.score;
      s1_found_q <= rec_i.found;
    end
  end

  // Load the output register when it is free or being taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      out_id_q    <= s1_id_q;
      out_pos_x_q <= pos_x_d;
      out_pos_y_q <= pos_y_d;
      out_score_q <= s1_score_q;
      out_found_q <= s1_found_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign keypoint_id_o = out_id_q;
  assign pos_x_o       = out_pos_x_q;
  assign pos_y_o       = out_pos_y_q;
  assign score_o       = out_score_q;
  assign found_o       = out_found_q;

  // A keypoint that was not found carries zero positions
  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_found_q) |-> (out_pos_x_q == 16'd0 && out_pos_y_q == 16'd0))
    else $error("nonzero position on a keypoint not found");

endmodule

@@ rtl/simcc_keypoint_argmax_decoder.sv @@
// ----------------------------------------------------------------------------
// simcc_keypoint_argmax_decoder: SimCC keypoint decoding by per-axis argmax
// Bin scores stream in; one keypoint result streams out per x/y bin set.
// ----------------------------------------------------------------------------
// The decoder takes one bin score per clock: for every keypoint the x-axis
// bins, then the y-axis bins, with tuser marking the first bin of a crop.
// The running argmax is a single compare per bin, so the input side sustains
// one transfer per cycle. After the last y bin a record enters a four-entry
// queue, and from there the result passes through the scale multiplication
// register and then the rounding into the output register. The input stalls
// only when that queue is full, i.e. when the output side has held off for
// several keypoints. Configuration writes are always taken and apply to the
// next bin; write them while no keypoint is in flight.
// ----------------------------------------------------------------------------
module simcc_keypoint_argmax_decoder #(
  parameter int unsigned MAX_BINS      = skad_pkg::MAX_BINS_DEF,
  parameter int unsigned MAX_KEYPOINTS = skad_pkg::MAX_KP_DEF,
  parameter int unsigned SCORE_WIDTH   = skad_pkg::SCORE_W_DEF,
  parameter int unsigned QUEUE_DEPTH   = skad_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [skad_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [skad_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Bin score input
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((SCORE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,  // bin_score
  input  logic                                s_axis_tuser,  // crop_start
  // Keypoint result output
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [55:0]                         m_axis_tdata,  // keypoint_id, pos_x, pos_y, score
  output logic                                m_axis_tuser   // found
);

  logic [10:0]       x_bin_count_q, y_bin_count_q;
  logic [8:0]        keypoint_count_q;
  logic [15:0]       scale_x_q, scale_y_q;

  logic              q_full, q_empty, q_push, q_pop;
  skad_pkg::kp_rec_t wr_rec, rd_rec;

  logic [7:0]        keypoint_id;
  logic [15:0]       pos_x, pos_y, score;
  logic              found;

  // Register file writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_bin_count_q    <= skad_pkg::X_BIN_COUNT_RST;
      y_bin_count_q    <= skad_pkg::Y_BIN_COUNT_RST;
      keypoint_count_q <= skad_pkg::KEYPOINT_COUNT_RST;
      scale_x_q        <= skad_pkg::SCALE_X_RST;
      scale_y_q        <= skad_pkg::SCALE_Y_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (skad_pkg::cfg_reg_e'(cfg_addr_i))
        skad_pkg::REG_X_BIN_COUNT:    x_bin_count_q    <= cfg_data_i[10:0];
        skad_pkg::REG_Y_BIN_COUNT:    y_bin_count_q    <= cfg_data_i[10:0];
        skad_pkg::REG_KEYPOINT_COUNT: keypoint_count_q <= cfg_data_i[8:0];
        skad_pkg::REG_SCALE_X:        scale_x_q        <= cfg_data_i;
        skad_pkg::REG_SCALE_Y:        scale_y_q        <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  skad_front #(
    .MAX_BINS      (MAX_BINS),
    .MAX_KEYPOINTS (MAX_KEYPOINTS),
    .SCORE_WIDTH   (SCORE_WIDTH)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .x_bin_count_i    (x_bin_count_q),
    .y_bin_count_i    (y_bin_count_q),
    .keypoint_count_i (keypoint_count_q),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .bin_score_i      (s_axis_tdata[SCORE_WIDTH-1:0]),
    .crop_start_i     (s_axis_tuser),
    .queue_full_i     (q_full),
    .push_o           (q_push),
    .rec_o            (wr_rec)
  );

  skad_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .wr_rec_i (wr_rec),
    .full_o   (q_full),
    .pop_i    (q_pop),
    .rd_rec_o (rd_rec),
    .empty_o  (q_empty)
  );

  skad_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .scale_x_i     (scale_x_q),
    .scale_y_i     (scale_y_q),
    .empty_i       (q_empty),
    .rec_i         (rd_rec),
    .pop_o         (q_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .keypoint_id_o (keypoint_id),
    .pos_x_o       (pos_x),
    .pos_y_o       (pos_y),
    .score_o       (score),
    .found_o       (found)
  );

  // Pack the result fields, lowest first
  assign m_axis_tdata = {score, pos_y, pos_x, keypoint_id};
  assign m_axis_tuser = found;

endmodule

@@ verif/keypoint_decode_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keypoint_decode_checker: result predictor and scoreboard for the decoder
// Watches the configuration, bin score and keypoint result channels, runs its
// own argmax model of every accepted bin score and compares each result
// transfer field by field against the oldest predicted keypoint.
// ----------------------------------------------------------------------------
module keypoint_decode_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [skad_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [skad_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Bin score channel
  input  logic                            bin_valid_i,
  input  logic                            bin_ready_i,
  input  logic [15:0]                     bin_data_i,   // bin_score
  input  logic                            bin_user_i,   // crop_start
  // Keypoint result channel
  input  logic                            kp_valid_i,
  input  logic                            kp_ready_i,
  input  logic [55:0]                     kp_data_i,    // keypoint_id, pos_x, pos_y, score
  input  logic                            kp_user_i,    // found
  output int unsigned                     mismatches_o,
  output int unsigned                     pending_o
);

  typedef struct packed {
    logic [7:0]  kp_id;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] score;
    logic        found;
  } kp_result_t;

  // Register copies
  logic [10:0] x_bins_cfg;
  logic [10:0] y_bins_cfg;
  logic [8:0]  kp_total_cfg;
  logic [15:0] x_scale_cfg;
  logic [15:0] y_scale_cfg;

  // Running argmax state
  logic signed [15:0] x_peak;
  logic signed [15:0] y_peak;
  int unsigned        x_peak_idx;
  int unsigned        y_peak_idx;
  int unsigned        bin_pos;
  logic               on_y;
  int unsigned        kp_num;

  kp_result_t  expected_kps[$];
  int unsigned errs;

  // Zero counts as one, anything past the limit as the limit
  function automatic int unsigned bounded_count(int unsigned c, int unsigned hi);
    if (c == 0) return 1;
    return (c > hi) ? hi : c;
  endfunction

  // Bin index times Q8.8 scale, rounded half up to Q12.4, saturated
  function automatic logic [15:0] bin_to_pos(int unsigned idx, logic [15:0] scl);
    longint unsigned p;
    p = idx;
    p = (p * scl + 8) >> 4;
    return (p > 65535) ? 16'hFFFF : p[15:0];
  endfunction

  // Advance the argmax by one bin; return 1 with the keypoint after its last y bin
  function automatic bit take_bin(logic signed [15:0] sc, logic crop, output kp_result_t kp);
    int unsigned        limit;
    logic signed [15:0] low;
    kp = '0;
    if (crop) begin
      kp_num  = 0;
      bin_pos = 0;
      on_y    = 1'b0;
    end
    if (!on_y) begin
      if (bin_pos == 0 || sc > x_peak) begin
        x_peak     = sc;
        x_peak_idx = bin_pos;
      end
      limit = bounded_count(x_bins_cfg, skad_pkg::MAX_BINS_DEF);
    end else begin
      if (bin_pos == 0 || sc > y_peak) begin
        y_peak     = sc;
        y_peak_idx = bin_pos;
      end
      limit = bounded_count(y_bins_cfg, skad_pkg::MAX_BINS_DEF);
    end
    if (bin_pos + 1 < limit) begin
      bin_pos++;
      return 1'b0;
    end
    bin_pos = 0;
    if (!on_y) begin
      on_y = 1'b1;
      return 1'b0;
    end
    on_y = 1'b0;
    low      = (x_peak > y_peak) ? y_peak : x_peak;
    kp.kp_id = kp_num[7:0];
    kp.score = low;
    kp.found = (low > 0);
    kp.pos_x = kp.found ? bin_to_pos(x_peak_idx, x_scale_cfg) : 16'h0000;
    kp.pos_y = kp.found ? bin_to_pos(y_peak_idx, y_scale_cfg) : 16'h0000;
    kp_num++;
    if (kp_num >= bounded_count(kp_total_cfg, skad_pkg::MAX_KP_DEF)) kp_num = 0;
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    kp_result_t want;
    kp_result_t got;
    if (!rst_ni) begin
      x_bins_cfg   = skad_pkg::X_BIN_COUNT_RST;
      y_bins_cfg   = skad_pkg::Y_BIN_COUNT_RST;
      kp_total_cfg = skad_pkg::KEYPOINT_COUNT_RST;
      x_scale_cfg  = skad_pkg::SCALE_X_RST;
      y_scale_cfg  = skad_pkg::SCALE_Y_RST;
      x_peak       = '0;
      y_peak       = '0;
      x_peak_idx   = 0;
      y_peak_idx   = 0;
      bin_pos      = 0;
      on_y         = 1'b0;
      kp_num       = 0;
      errs         = 0;
      expected_kps.delete();
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      // Compare a result transfer against the oldest prediction
      if (kp_valid_i && kp_ready_i) begin
        got.kp_id = kp_data_i[7:0];
        got.pos_x = kp_data_i[23:8];
        got.pos_y = kp_data_i[39:24];
        got.score = kp_data_i[55:40];
        got.found = kp_user_i;
        if (expected_kps.size() == 0) begin
          $error("unexpected keypoint result: id %0d pos_x %0d pos_y %0d score %0d found %0b",
                 got.kp_id, got.pos_x, got.pos_y, $signed(got.score), got.found);
          errs++;
        end else begin
          want = expected_kps.pop_front();
          if (got.kp_id !== want.kp_id) begin
            $error("keypoint_id: expected %0d, got %0d", want.kp_id, got.kp_id);
            errs++;
          end
          if (got.pos_x !== want.pos_x) begin
            $error("pos_x: expected %0d, got %0d", want.pos_x, got.pos_x);
            errs++;
          end
          if (got.pos_y !== want.pos_y) begin
            $error("pos_y: expected %0d, got %0d", want.pos_y, got.pos_y);
            errs++;
          end
          if (got.score !== want.score) begin
            $error("score: expected %0d, got %0d", $signed(want.score), $signed(got.score));
            errs++;
          end
          if (got.found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, got.found);
            errs++;
          end
        end
      end

      // Predict from each accepted bin score
      if (bin_valid_i && bin_ready_i) begin
        if (take_bin(bin_data_i, bin_user_i, want)) begin
          expected_kps.insert(expected_kps.size(), want);
        end
      end

      // Track register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (skad_pkg::cfg_reg_e'(cfg_addr_i))
          skad_pkg::REG_X_BIN_COUNT:    x_bins_cfg   = cfg_data_i[10:0];
          skad_pkg::REG_Y_BIN_COUNT:    y_bins_cfg   = cfg_data_i[10:0];
          skad_pkg::REG_KEYPOINT_COUNT: kp_total_cfg = cfg_data_i[8:0];
          skad_pkg::REG_SCALE_X:        x_scale_cfg  = cfg_data_i;
          skad_pkg::REG_SCALE_Y:        y_scale_cfg  = cfg_data_i;
          default: ;
        endcase
      end

      mismatches_o <= errs;
      pending_o    <= expected_kps.size();
    end
  end

endmodule

@@ verif/tb_simcc_keypoint_argmax_decoder.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_simcc_keypoint_argmax_decoder: stimulus and verdict for the decoder
// Drives directed keypoints (score extremes, ties, crop restart mid-keypoint,
// bin count lowered mid-axis), a run at a keypoint count past the limit, a
// stretch without gaps whose x peak saturates, then randomized phases under
// random register settings, with random gaps on both sides. The checker
// beside the block scores results.
// ----------------------------------------------------------------------------
module tb_simcc_keypoint_argmax_decoder;

  typedef enum int unsigned {
    MIX_FULL,
    MIX_NEAR_ZERO,
    MIX_POSITIVE
  } score_mix_e;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            cfg_valid_i   = 1'b0;
  logic                            cfg_ready_o;
  logic [skad_pkg::CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [skad_pkg::CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [15:0]                     s_axis_tdata  = '0;   // bin_score
  logic                            s_axis_tuser  = 1'b0; // crop_start
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [55:0]                     m_axis_tdata;         // keypoint_id, pos_x, pos_y, score
  logic                            m_axis_tuser;         // found

  int unsigned mismatches;
  int unsigned pending;
  bit          gaps_on    = 1'b1;
  int unsigned stall_left = 0;
  int unsigned bins_sent  = 0;

  simcc_keypoint_argmax_decoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  keypoint_decode_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .bin_valid_i  (s_axis_tvalid),
    .bin_ready_i  (s_axis_tready),
    .bin_data_i   (s_axis_tdata),
    .bin_user_i   (s_axis_tuser),
    .kp_valid_i   (m_axis_tvalid),
    .kp_ready_i   (m_axis_tready),
    .kp_data_i    (m_axis_tdata),
    .kp_user_i    (m_axis_tuser),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Bound the run
  initial begin
    #5ms;
    $display("tb_simcc_keypoint_argmax_decoder: FAIL");
    $finish;
  end

  // Pace the result side: short random stalls, now and then a long hold to fill the queue
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(999) < 5) begin
      stall_left    <= $urandom_range(24, 12);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(gaps_on && $urandom_range(99) < 4);
    end
  end

  function automatic logic [15:0] pick_score(score_mix_e mix);
    case (mix)
      MIX_FULL:      return 16'($urandom);
      MIX_NEAR_ZERO: return 16'($urandom_range(6) - 3);
      default:       return 16'($urandom_range(32767, 1));
    endcase
  endfunction

  function automatic int unsigned pick_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 80) return $urandom_range(6, 1);
    return $urandom_range(32, 7);
  endfunction

  function automatic logic [15:0] pick_scale();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    if (r < 5) return 16'($urandom_range(16'h0300, 1));
    return 16'($urandom);
  endfunction

  // Present one bin score and hold it until the transfer
  task automatic send_bin(logic [15:0] sc, logic crop);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(99) < 10) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = sc;
    s_axis_tuser  = crop;
    do @(posedge clk_i); while (!s_axis_tready);
    bins_sent++;
  endtask

  // Drop valid, wait for every predicted result, then let the pipeline empty
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(skad_pkg::cfg_reg_e r, logic [15:0] v);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_addr_i  = r;
    cfg_data_i  = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_config(logic [15:0] xc, logic [15:0] yc, logic [15:0] kc,
                            logic [15:0] sx, logic [15:0] sy);
    write_reg(skad_pkg::REG_X_BIN_COUNT, xc);
    write_reg(skad_pkg::REG_Y_BIN_COUNT, yc);
    write_reg(skad_pkg::REG_KEYPOINT_COUNT, kc);
    write_reg(skad_pkg::REG_SCALE_X, sx);
    write_reg(skad_pkg::REG_SCALE_Y, sy);
  endtask

  initial begin
    int unsigned xc;
    int unsigned yc;
    int unsigned kc;
    int unsigned nx;
    int unsigned ny;
    int unsigned goal;
    score_mix_e  mix;

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed: two x bins, three y bins, ids wrap after three keypoints
    set_config(16'd2, 16'd3, 16'd3, 16'h0100, 16'hFFFF);
    // positive extremes; y tie keeps the earlier bin
    send_bin(16'h8000, 1'b1);
    send_bin(16'h7FFF, 1'b0);
    send_bin(16'h0001, 1'b0);
    send_bin(16'h7FFF, 1'b0);
    send_bin(16'h7FFF, 1'b0);
    // all zero: not found
    send_bin(16'h0000, 1'b0);
    send_bin(16'h0000, 1'b0);
    send_bin(16'h0000, 1'b0);
    send_bin(16'h0000, 1'b0);
    send_bin(16'h0000, 1'b0);
    // most negative scores, first y bin at -1: first bin loads, index zero holds on each axis
    send_bin(16'h8000, 1'b0);
    send_bin(16'h8000, 1'b0);
    send_bin(16'hFFFF, 1'b0);
    send_bin(16'h8000, 1'b0);
    send_bin(16'h8000, 1'b0);
    // crop restart in the y axis drops the partial keypoint
    send_bin(16'h0100, 1'b0);
    send_bin(16'h0200, 1'b0);
    send_bin(16'h0005, 1'b0);
    send_bin(16'h0300, 1'b1);
    send_bin(16'h0050, 1'b0);
    send_bin(16'h0300, 1'b0);
    send_bin(16'h0400, 1'b0);
    send_bin(16'h0002, 1'b0);
    drain();

    // x count lowered below the bin counter mid-axis
    write_reg(skad_pkg::REG_X_BIN_COUNT, 16'd6);
    send_bin(16'h0010, 1'b1);
    send_bin(16'h0040, 1'b0);
    send_bin(16'h0020, 1'b0);
    send_bin(16'h0030, 1'b0);
    drain();
    write_reg(skad_pkg::REG_X_BIN_COUNT, 16'd2);
    send_bin(16'h0050, 1'b0);
    send_bin(16'h0001, 1'b0);
    send_bin(16'h0002, 1'b0);
    send_bin(16'h0003, 1'b0);
    drain();

    // One bin per axis, keypoint count past the limit: ids keep counting up
    set_config(16'd1, 16'd1, 16'd300, pick_scale(), pick_scale());
    for (int k = 0; k < 20; k++) begin
      mix = score_mix_e'($urandom_range(2));
      send_bin(pick_score(mix), k == 0);
      send_bin(pick_score(mix), 1'b0);
    end
    drain();

    // No gaps: the x peak sits on the last bin and its position saturates
    gaps_on = 1'b0;
    set_config(16'd40, 16'd24, 16'd1, 16'hFFFF, 16'h0010);
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < 40; i++) begin
        send_bin((i == 39) ? 16'h7FFF : 16'($urandom_range(16'h7FFE, 1)), k == 0 && i == 0);
      end
      for (int i = 0; i < 24; i++) begin
        send_bin(16'($urandom_range(16'h7000, 1)), 1'b0);
      end
    end
    drain();
    gaps_on = 1'b1;

    // Random phases: mostly whole keypoints with random content, some noise
    goal = bins_sent + 420;
    while (bins_sent < goal) begin
      drain();
      xc = pick_count();
      yc = pick_count();
      kc = $urandom_range(99);
      if (kc < 10) begin
        kc = 0;
      end else if (kc < 20) begin
        kc = $urandom_range(511, 256);
      end else begin
        kc = $urandom_range(6, 1);
      end
      set_config(16'(xc), 16'(yc), 16'(kc), pick_scale(), pick_scale());
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(20, 5)) send_bin(16'($urandom), $urandom_range(99) < 30);
      end else begin
        nx = (xc == 0) ? 1 : xc;
        ny = (yc == 0) ? 1 : yc;
        for (int k = 0; k < $urandom_range(10, 2); k++) begin
          mix = score_mix_e'($urandom_range(2));
          for (int i = 0; i < nx + ny; i++) begin
            send_bin(pick_score(mix), (k == 0 && i == 0) || $urandom_range(99) < 2);
          end
        end
      end
    end
    drain();
    repeat (20) @(negedge clk_i);

    if (mismatches == 0 && pending == 0) begin
      $display("tb_simcc_keypoint_argmax_decoder: PASS");
    end else begin
      $display("tb_simcc_keypoint_argmax_decoder: FAIL");
    end
    $finish;
  end

endmodule
